@@ rtl/ansi_csi_escape_parser_unit_macros.svh @@
// Assertion macros used by the checker file of the CSI parser.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ANSI_CSI_ESCAPE_PARSER_UNIT_MACROS_SVH
`define ANSI_CSI_ESCAPE_PARSER_UNIT_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define CSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define CSI_ASSERT_IMPL(lbl, cond, cons, msg) \
  `CSI_ASSERT(lbl, (cond) |-> (cons), msg)

`endif

@@ rtl/csi_pkg.sv @@
// Shared types and constants of the CSI escape parser.
// No dependencies.
package csi_pkg;

  localparam logic [2:0] KIND_CHAR   = 3'd0;
  localparam logic [2:0] KIND_STYLE  = 3'd1;
  localparam logic [2:0] KIND_CURSOR = 3'd2;
  localparam logic [2:0] KIND_ELINE  = 3'd3;
  localparam logic [2:0] KIND_ESCR   = 3'd4;

  localparam logic [1:0] PH_TEXT = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_CSI  = 2'd2;

  localparam logic [1:0] MODE_PAL = 2'd0;
  localparam logic [1:0] MODE_IDX = 2'd1;
  localparam logic [1:0] MODE_RGB = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DFG    = 2'd2;
  localparam logic [1:0] REG_DBG    = 2'd3;

  localparam logic [7:0] WIDTH_RESET  = 8'd80;
  localparam logic [7:0] HEIGHT_RESET = 8'd25;
  localparam logic [3:0] DFG_RESET    = 4'd7;
  localparam logic [3:0] DBG_RESET    = 4'd0;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_M = 8'h6D;
  localparam logic [7:0] CH_UP_H  = 8'h48;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_UP_K  = 8'h4B;
  localparam logic [7:0] CH_UP_J  = 8'h4A;

  localparam int SGR_RESET   = 0;
  localparam int SGR_INVERT  = 7;
  localparam int SGR_FG_EXT  = 38;
  localparam int SGR_BG_EXT  = 48;
  localparam int SGR_FG_DEF  = 39;
  localparam int SGR_BG_DEF  = 49;
  localparam int SGR_FG_BASE = 30;
  localparam int SGR_BG_BASE = 40;
  localparam int SGR_FG_BRT  = 90;
  localparam int SGR_BG_BRT  = 100;
  localparam int SGR_CLR_BASE = 21;
  localparam logic [7:0] SEL_IDX = 8'd5;
  localparam logic [7:0] SEL_RGB = 8'd2;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  out_char;
    logic [1:0]  fg_mode;
    logic [23:0] fg_value;
    logic [1:0]  bg_mode;
    logic [23:0] bg_value;
    logic [2:0]  style_flags;
    logic [7:0]  cursor_row;
    logic [7:0]  cursor_col;
    logic [1:0]  erase_mode;
  } res_t;

endpackage

@@ rtl/csi_in_if.sv @@
// Byte input channel of the CSI parser.
// No dependencies.
interface csi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

@@ rtl/csi_out_if.sv @@
// Result channel of the CSI parser.
// No dependencies.
interface csi_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [7:0]  out_char;
  logic [1:0]  fg_mode;
  logic [23:0] fg_value;
  logic [1:0]  bg_mode;
  logic [23:0] bg_value;
  logic [2:0]  style_flags;
  logic [7:0]  cursor_row;
  logic [7:0]  cursor_col;
  logic [1:0]  erase_mode;
  modport source (output valid, output result_kind, output out_char, output fg_mode,
                  output fg_value, output bg_mode, output bg_value, output style_flags,
                  output cursor_row, output cursor_col, output erase_mode, input ready);
  modport sink (input valid, input result_kind, input out_char, input fg_mode,
                input fg_value, input bg_mode, input bg_value, input style_flags,
                input cursor_row, input cursor_col, input erase_mode, output ready);
endinterface

@@ rtl/ansi_csi_escape_parser_unit.sv @@
// ANSI CSI escape parser top level: byte parser, parameter stack memory, SGR walk.
// Depends on csi_pkg, csi_in_if and csi_out_if.
//
//   channel   dir   handshake        payload
//   in_ch     in    valid/ready      in_byte
//   out_ch    out   valid/ready      result_kind .. erase_mode
//   cfg_*     in    cfg_we           cfg_index, cfg_wdata
//
// Text, digit and ';' bytes are handled in ST_IDLE without leaving it.
// A final 'm' walks the stack through one read port, fetching each parameter
// (ST_FETCH) and applying it (ST_CODE). 'H'/'f' pass ST_PFETCH, ST_P0, ST_P1; 'K'/'J' ST_PFETCH, ST_P0.
// Reset is synchronous and active low; the stack needs no clearing pass.
// in_ch.ready drops during a walk and while an untaken result would block.
module ansi_csi_escape_parser_unit #(
  parameter int PARAM_DEPTH = 16,
  parameter int PARAM_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  csi_in_if.sink     in_ch,
  csi_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import csi_pkg::*;

  localparam int AW = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
  localparam int IW = AW + 3;
  localparam int PW = PARAM_BITS + 4;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_FETCH  = 4'd1;
  localparam logic [3:0] ST_CODE   = 4'd2;
  localparam logic [3:0] ST_SEL    = 4'd3;
  localparam logic [3:0] ST_IDX    = 4'd4;
  localparam logic [3:0] ST_RED    = 4'd5;
  localparam logic [3:0] ST_GRN    = 4'd6;
  localparam logic [3:0] ST_BLU    = 4'd7;
  localparam logic [3:0] ST_PFETCH = 4'd8;
  localparam logic [3:0] ST_P0     = 4'd9;
  localparam logic [3:0] ST_P1     = 4'd10;

  logic [PARAM_BITS-1:0] mem [PARAM_DEPTH];

  logic [7:0]  width_r, height_r;
  logic [3:0]  dfg_r, dbg_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  st_r, st_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [PARAM_BITS-1:0] acc_r, acc_nxt;
  logic [IW-1:0] i_r, i_nxt, cnt_r, cnt_nxt;
  logic [2:0]  fin_r, fin_nxt;
  logic        isbg_r, isbg_nxt;
  logic [7:0]  red_r, red_nxt, grn_r, grn_nxt;
  logic [PARAM_BITS-1:0] p0_r, p0_nxt;
  logic [1:0]  fgm_r, fgm_nxt, bgm_r, bgm_nxt;
  logic [23:0] fgv_r, fgv_nxt, bgv_r, bgv_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic        ovalid_r;
  res_t        res_r, res_nxt;
  logic        emit;

  logic        mem_we;
  logic [IW-1:0] rd_idx;
  logic [PARAM_BITS-1:0] rdata_r;
  logic        rd_ok_r;

  logic        in_acc;
  logic [7:0]  b;
  logic [PW-1:0] prod;
  logic [PARAM_BITS-1:0] n, pv, sub;
  logic [IW-1:0] i1, i2, i3, i4, i5;
  logic [7:0]  hi0, wd0, rowc, colc;

  assign b      = in_ch.in_byte;
  assign in_ch.ready = (st_r == ST_IDLE) && (!ovalid_r || out_ch.ready);
  assign in_acc = in_ch.valid && in_ch.ready;

  assign i1 = i_r + IW'(1);
  assign i2 = i_r + IW'(2);
  assign i3 = i_r + IW'(3);
  assign i4 = i_r + IW'(4);
  assign i5 = i_r + IW'(5);
  assign n  = rdata_r;
  assign pv = rd_ok_r ? rdata_r : '0;

  // acc*10 + digit as two shifts and two adds; any carry past PARAM_BITS saturates.
  assign prod = (PW'(acc_r) << 3) + (PW'(acc_r) << 1) + PW'(b[3:0]);

  // Cursor clamp: zero limits act as one, zero parameters as one.
  assign hi0 = (height_r == 8'd0) ? 8'd1 : height_r;
  assign wd0 = (width_r == 8'd0) ? 8'd1 : width_r;
  assign rowc = (p0_r == '0) ? 8'd0 :
                (p0_r > PARAM_BITS'(hi0)) ? hi0 - 8'd1 : p0_r[7:0] - 8'd1;
  assign colc = (pv == '0) ? 8'd0 :
                (pv > PARAM_BITS'(wd0)) ? wd0 - 8'd1 : pv[7:0] - 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    st_nxt    = st_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    i_nxt     = i_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    isbg_nxt  = isbg_r;
    red_nxt   = red_r;
    grn_nxt   = grn_r;
    p0_nxt    = p0_r;
    fgm_nxt   = fgm_r;
    fgv_nxt   = fgv_r;
    bgm_nxt   = bgm_r;
    bgv_nxt   = bgv_r;
    flags_nxt = flags_r;
    mem_we    = 1'b0;
    rd_idx    = i_r;
    emit      = 1'b0;
    res_nxt   = '0;
    sub       = '0;

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (phase_r)
            PH_TEXT: begin
              if (b == CH_ESC) begin
                phase_nxt = PH_ESC;
              end else begin
                emit = 1'b1;
                res_nxt.result_kind = KIND_CHAR;
                res_nxt.out_char = b;
              end
            end
            PH_ESC: begin
              if (b == CH_LBRK) begin
                phase_nxt = PH_CSI;
                pos_nxt   = '0;
                acc_nxt   = '0;
              end else begin
                phase_nxt = PH_TEXT;
                emit = 1'b1;
                res_nxt.result_kind = KIND_CHAR;
                res_nxt.out_char = b;
              end
            end
            PH_CSI: begin
              if (b >= CH_ZERO && b <= CH_NINE) begin
                acc_nxt = (|prod[PW-1:PARAM_BITS]) ? '1 : prod[PARAM_BITS-1:0];
              end else if (b == CH_SEMI) begin
                acc_nxt = '0;
                if (pos_r == AW'(PARAM_DEPTH - 1)) begin
                  // Stack overflow abandons the sequence.
                  pos_nxt   = '0;
                  phase_nxt = PH_TEXT;
                end else begin
                  mem_we  = 1'b1;
                  pos_nxt = pos_r + AW'(1);
                end
              end else begin
                mem_we    = 1'b1;
                cnt_nxt   = IW'(pos_r) + IW'(1);
                pos_nxt   = '0;
                acc_nxt   = '0;
                phase_nxt = PH_TEXT;
                i_nxt     = '0;
                if (b == CH_LOW_M) begin
                  st_nxt = ST_FETCH;
                end else if (b == CH_UP_H || b == CH_LOW_F) begin
                  fin_nxt = KIND_CURSOR;
                  st_nxt  = ST_PFETCH;
                end else if (b == CH_UP_K) begin
                  fin_nxt = KIND_ELINE;
                  st_nxt  = ST_PFETCH;
                end else if (b == CH_UP_J) begin
                  fin_nxt = KIND_ESCR;
                  st_nxt  = ST_PFETCH;
                end
              end
            end
            default: phase_nxt = PH_TEXT;
          endcase
        end
      end

      ST_FETCH: begin
        if (i_r >= cnt_r) begin
          emit   = 1'b1;
          st_nxt = ST_IDLE;
        end else begin
          rd_idx = i_r;
          st_nxt = ST_CODE;
        end
      end

      ST_CODE: begin
        if (n == PARAM_BITS'(SGR_FG_EXT) || n == PARAM_BITS'(SGR_BG_EXT)) begin
          isbg_nxt = (n == PARAM_BITS'(SGR_BG_EXT));
          if (i1 >= cnt_r) begin
            emit   = 1'b1;
            st_nxt = ST_IDLE;
          end else begin
            rd_idx = i1;
            st_nxt = ST_SEL;
          end
        end else begin
          i_nxt  = i1;
          st_nxt = ST_FETCH;
          if (n == PARAM_BITS'(SGR_RESET)) begin
            fgm_nxt = MODE_PAL;
            fgv_nxt = 24'(dfg_r);
            bgm_nxt = MODE_PAL;
            bgv_nxt = 24'(dbg_r);
            flags_nxt = '0;
          end else if (n >= PARAM_BITS'(1) && n <= PARAM_BITS'(3)) begin
            flags_nxt = flags_r | (3'b001 << (n[1:0] - 2'd1));
          end else if (n >= PARAM_BITS'(SGR_CLR_BASE) &&
                       n <= PARAM_BITS'(SGR_CLR_BASE + 2)) begin
            sub = n - PARAM_BITS'(SGR_CLR_BASE);
            flags_nxt = flags_r & ~(3'b001 << sub[1:0]);
          end else if (n == PARAM_BITS'(SGR_INVERT)) begin
            fgm_nxt = bgm_r;
            fgv_nxt = bgv_r;
            bgm_nxt = fgm_r;
            bgv_nxt = fgv_r;
          end else if (n >= PARAM_BITS'(SGR_FG_BASE) &&
                       n <= PARAM_BITS'(SGR_FG_BASE + 7)) begin
            sub = n - PARAM_BITS'(SGR_FG_BASE);
            fgm_nxt = MODE_PAL;
            fgv_nxt = 24'(sub[2:0]);
          end else if (n == PARAM_BITS'(SGR_FG_DEF)) begin
            fgm_nxt = MODE_PAL;
            fgv_nxt = 24'(dfg_r);
          end else if (n >= PARAM_BITS'(SGR_BG_BASE) &&
                       n <= PARAM_BITS'(SGR_BG_BASE + 7)) begin
            sub = n - PARAM_BITS'(SGR_BG_BASE);
            bgm_nxt = MODE_PAL;
            bgv_nxt = 24'(sub[2:0]);
          end else if (n == PARAM_BITS'(SGR_BG_DEF)) begin
            bgm_nxt = MODE_PAL;
            bgv_nxt = 24'(dbg_r);
          end else if (n >= PARAM_BITS'(SGR_FG_BRT) &&
                       n <= PARAM_BITS'(SGR_FG_BRT + 7)) begin
            sub = n - PARAM_BITS'(SGR_FG_BRT);
            fgm_nxt = MODE_PAL;
            fgv_nxt = 24'({1'b1, sub[2:0]});
          end else if (n >= PARAM_BITS'(SGR_BG_BRT) &&
                       n <= PARAM_BITS'(SGR_BG_BRT + 7)) begin
            sub = n - PARAM_BITS'(SGR_BG_BRT);
            bgm_nxt = MODE_PAL;
            bgv_nxt = 24'({1'b1, sub[2:0]});
          end
        end
      end

      ST_SEL: begin
        if (n[7:0] == SEL_IDX) begin
          if (i2 >= cnt_r) begin
            emit   = 1'b1;
            st_nxt = ST_IDLE;
          end else begin
            rd_idx = i2;
            st_nxt = ST_IDX;
          end
        end else if (n[7:0] == SEL_RGB) begin
          if (i4 >= cnt_r) begin
            emit   = 1'b1;
            st_nxt = ST_IDLE;
          end else begin
            rd_idx = i2;
            st_nxt = ST_RED;
          end
        end else begin
          i_nxt  = i2;
          st_nxt = ST_FETCH;
        end
      end

      ST_IDX: begin
        if (isbg_r) begin
          bgm_nxt = MODE_IDX;
          bgv_nxt = 24'(n[7:0]);
        end else begin
          fgm_nxt = MODE_IDX;
          fgv_nxt = 24'(n[7:0]);
        end
        i_nxt  = i3;
        st_nxt = ST_FETCH;
      end

      ST_RED: begin
        red_nxt = n[7:0];
        rd_idx  = i3;
        st_nxt  = ST_GRN;
      end

      ST_GRN: begin
        grn_nxt = n[7:0];
        rd_idx  = i4;
        st_nxt  = ST_BLU;
      end

      ST_BLU: begin
        if (isbg_r) begin
          bgm_nxt = MODE_RGB;
          bgv_nxt = {red_r, grn_r, n[7:0]};
        end else begin
          fgm_nxt = MODE_RGB;
          fgv_nxt = {red_r, grn_r, n[7:0]};
        end
        i_nxt  = i5;
        st_nxt = ST_FETCH;
      end

      ST_PFETCH: begin
        rd_idx = '0;
        st_nxt = ST_P0;
      end

      ST_P0: begin
        p0_nxt = pv;
        if (fin_r == KIND_CURSOR) begin
          rd_idx = IW'(1);
          st_nxt = ST_P1;
        end else begin
          emit = 1'b1;
          res_nxt.result_kind = fin_r;
          res_nxt.erase_mode = (pv <= PARAM_BITS'(2)) ? pv[1:0] : 2'd0;
          st_nxt = ST_IDLE;
        end
      end

      ST_P1: begin
        emit = 1'b1;
        res_nxt.result_kind = KIND_CURSOR;
        res_nxt.cursor_row = rowc;
        res_nxt.cursor_col = colc;
        st_nxt = ST_IDLE;
      end

      default: st_nxt = ST_IDLE;
    endcase

    // Style results carry the style as it stands when the walk ends.
    if (emit && st_r != ST_IDLE && st_r != ST_P0 && st_r != ST_P1) begin
      res_nxt.result_kind = KIND_STYLE;
      res_nxt.fg_mode     = fgm_r;
      res_nxt.fg_value    = fgv_r;
      res_nxt.bg_mode     = bgm_r;
      res_nxt.bg_value    = bgv_r;
      res_nxt.style_flags = flags_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos_r] <= acc_r;
    end
    rdata_r <= mem[rd_idx[AW-1:0]];
    rd_ok_r <= (rd_idx < cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      dfg_r    <= DFG_RESET;
      dbg_r    <= DBG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        REG_DFG:    dfg_r    <= cfg_wdata[3:0];
        REG_DBG:    dbg_r    <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TEXT;
      st_r     <= ST_IDLE;
      pos_r    <= '0;
      acc_r    <= '0;
      i_r      <= '0;
      cnt_r    <= IW'(1);
      fin_r    <= KIND_CHAR;
      isbg_r   <= 1'b0;
      fgm_r    <= MODE_PAL;
      fgv_r    <= 24'(DFG_RESET);
      bgm_r    <= MODE_PAL;
      bgv_r    <= 24'(DBG_RESET);
      flags_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      st_r     <= st_nxt;
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
      i_r      <= i_nxt;
      cnt_r    <= cnt_nxt;
      fin_r    <= fin_nxt;
      isbg_r   <= isbg_nxt;
      fgm_r    <= fgm_nxt;
      fgv_r    <= fgv_nxt;
      bgm_r    <= bgm_nxt;
      bgv_r    <= bgv_nxt;
      flags_r  <= flags_nxt;
      if (emit) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    red_r <= red_nxt;
    grn_r <= grn_nxt;
    p0_r  <= p0_nxt;
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.result_kind = res_r.result_kind;
  assign out_ch.out_char    = res_r.out_char;
  assign out_ch.fg_mode     = res_r.fg_mode;
  assign out_ch.fg_value    = res_r.fg_value;
  assign out_ch.bg_mode     = res_r.bg_mode;
  assign out_ch.bg_value    = res_r.bg_value;
  assign out_ch.style_flags = res_r.style_flags;
  assign out_ch.cursor_row  = res_r.cursor_row;
  assign out_ch.cursor_col  = res_r.cursor_col;
  assign out_ch.erase_mode  = res_r.erase_mode;

endmodule

@@ rtl/csi_checker.sv @@
// Port-level checks of the CSI parser, bound to its top level.
// Depends on csi_pkg and ansi_csi_escape_parser_unit_macros.svh.
`include "ansi_csi_escape_parser_unit_macros.svh"

module csi_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] result_kind,
  input logic [7:0] out_char,
  input logic [7:0] cursor_row,
  input logic [7:0] cursor_col
);
  import csi_pkg::*;

  `CSI_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")
  `CSI_ASSERT_IMPL(a_kind_range, out_valid, result_kind <= KIND_ESCR, "bad result kind")
  `CSI_ASSERT_IMPL(a_char_zero, out_valid && result_kind != KIND_CHAR, out_char == 8'd0, "char set")
  `CSI_ASSERT_IMPL(a_cursor_rng, out_valid && result_kind == KIND_CURSOR,
    cursor_row != 8'hFF && cursor_col != 8'hFF, "cursor beyond clamp")

endmodule

bind ansi_csi_escape_parser_unit csi_checker u_csi_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .result_kind (out_ch.result_kind),
  .out_char    (out_ch.out_char),
  .cursor_row  (out_ch.cursor_row),
  .cursor_col  (out_ch.cursor_col)
);

@@ test/tb_top.sv @@
// Testbench of the ANSI CSI escape parser: byte stimulus in, decoded results out.
// Depends on csi_pkg, csi_in_if, csi_out_if and ansi_csi_escape_parser_unit.
// A local parser model predicts the random results, directed rows give their own; results are compared field by field.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import csi_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_WIDTH;
  logic [7:0] cfg_wdata = 8'd0;

  csi_in_if in_ch ();
  csi_out_if out_ch ();

  ansi_csi_escape_parser_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Parser model state.
  logic [7:0] m_width, m_height;
  logic [3:0] m_dfg, m_dbg;
  logic [1:0] m_phase;
  logic [15:0] m_stack [16];
  int m_pos;
  logic [1:0] m_fg_mode, m_bg_mode;
  logic [23:0] m_fg_val, m_bg_val;
  logic [2:0] m_flags;

  res_t pending_results[$];
  logic [7:0] byte_stream[$];
  int fails = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  bit hold_req = 1'b0;

  typedef struct {
    logic [7:0] b;
    bit typed;
    res_t want;
  } row_t;
  row_t directed_rows[$];

  task automatic clear_stack();
    for (int i = 0; i < 16; i++) m_stack[i] = '0;
    m_pos = 0;
  endtask

  task automatic apply_sgr(input int n);
    logic [1:0] tm;
    logic [23:0] tv;
    if (n == SGR_RESET) begin
      m_fg_mode = MODE_PAL; m_fg_val = 24'(m_dfg);
      m_bg_mode = MODE_PAL; m_bg_val = 24'(m_dbg);
      m_flags = '0;
    end else if (n >= 1 && n <= 3) begin
      m_flags[n-1] = 1'b1;
    end else if (n >= SGR_CLR_BASE && n <= SGR_CLR_BASE + 2) begin
      m_flags[n-SGR_CLR_BASE] = 1'b0;
    end else if (n == SGR_INVERT) begin
      tm = m_fg_mode; tv = m_fg_val;
      m_fg_mode = m_bg_mode; m_fg_val = m_bg_val;
      m_bg_mode = tm; m_bg_val = tv;
    end else if (n >= SGR_FG_BASE && n <= SGR_FG_BASE + 7) begin
      m_fg_mode = MODE_PAL; m_fg_val = 24'(n - SGR_FG_BASE);
    end else if (n == SGR_FG_DEF) begin
      m_fg_mode = MODE_PAL; m_fg_val = 24'(m_dfg);
    end else if (n >= SGR_BG_BASE && n <= SGR_BG_BASE + 7) begin
      m_bg_mode = MODE_PAL; m_bg_val = 24'(n - SGR_BG_BASE);
    end else if (n == SGR_BG_DEF) begin
      m_bg_mode = MODE_PAL; m_bg_val = 24'(m_dbg);
    end else if (n >= SGR_FG_BRT && n <= SGR_FG_BRT + 7) begin
      m_fg_mode = MODE_PAL; m_fg_val = 24'(n - SGR_FG_BRT + 8);
    end else if (n >= SGR_BG_BRT && n <= SGR_BG_BRT + 7) begin
      m_bg_mode = MODE_PAL; m_bg_val = 24'(n - SGR_BG_BRT + 8);
    end
  endtask

  task automatic walk_sgr(input int count);
    int i;
    int n;
    logic [7:0] sel;
    logic [1:0] mode;
    logic [23:0] val;
    i = 0;
    while (i < count) begin
      n = m_stack[i];
      if (n == SGR_FG_EXT || n == SGR_BG_EXT) begin
        if (i + 1 >= count) break;
        sel = m_stack[i+1][7:0];
        if (sel == SEL_IDX) begin
          if (i + 2 >= count) break;
          mode = MODE_IDX;
          val = {16'd0, m_stack[i+2][7:0]};
          i += 3;
        end else if (sel == SEL_RGB) begin
          if (i + 4 >= count) break;
          mode = MODE_RGB;
          val = {m_stack[i+2][7:0], m_stack[i+3][7:0], m_stack[i+4][7:0]};
          i += 5;
        end else begin
          i += 2;
          continue;
        end
        if (n == SGR_FG_EXT) begin
          m_fg_mode = mode; m_fg_val = val;
        end else begin
          m_bg_mode = mode; m_bg_val = val;
        end
      end else begin
        apply_sgr(n);
        i++;
      end
    end
  endtask

  function automatic logic [7:0] clamp_pos(input int v, input int hi);
    if (hi == 0) hi = 1;
    if (v < 1) v = 1;
    if (v > hi) v = hi;
    return 8'(v - 1);
  endfunction

  // Advances the parser model by one byte; has is set when a result comes out.
  task automatic parse_byte(input logic [7:0] b, output bit has, output res_t r);
    int v;
    r = '0;
    has = 1'b0;
    if (m_phase == PH_TEXT) begin
      if (b == CH_ESC) m_phase = PH_ESC;
      else begin
        r.result_kind = KIND_CHAR; r.out_char = b; has = 1'b1;
      end
    end else if (m_phase == PH_ESC) begin
      if (b == CH_LBRK) begin
        m_phase = PH_CSI;
        clear_stack();
      end else begin
        m_phase = PH_TEXT;
        r.result_kind = KIND_CHAR; r.out_char = b; has = 1'b1;
      end
    end else if (m_phase != PH_CSI) begin
      m_phase = PH_TEXT;
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      v = m_stack[m_pos] * 10 + (b - CH_ZERO);
      m_stack[m_pos] = (v > 65535) ? 16'hFFFF : v[15:0];
    end else if (b == CH_SEMI) begin
      if (m_pos + 1 < 16) m_pos++;
      else begin
        clear_stack();
        m_phase = PH_TEXT;
      end
    end else begin
      if (b == CH_LOW_M) begin
        walk_sgr(m_pos + 1);
        r.result_kind = KIND_STYLE;
        r.fg_mode = m_fg_mode; r.fg_value = m_fg_val;
        r.bg_mode = m_bg_mode; r.bg_value = m_bg_val;
        r.style_flags = m_flags;
        has = 1'b1;
      end else if (b == CH_UP_H || b == CH_LOW_F) begin
        r.result_kind = KIND_CURSOR;
        r.cursor_row = clamp_pos(m_stack[0], m_height);
        r.cursor_col = clamp_pos(m_stack[1], m_width);
        has = 1'b1;
      end else if (b == CH_UP_K || b == CH_UP_J) begin
        r.result_kind = (b == CH_UP_K) ? KIND_ELINE : KIND_ESCR;
        r.erase_mode = (m_stack[0] <= 2) ? m_stack[0][1:0] : 2'd0;
        has = 1'b1;
      end
      clear_stack();
      m_phase = PH_TEXT;
    end
  endtask

  task automatic report(input string field, input int got, input int want);
    $display("result %s: got %0d, expected %0d", field, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    res_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) report("without expectation, kind", out_ch.result_kind, -1);
      else begin
        w = pending_results.pop_front();
        if (out_ch.result_kind !== w.result_kind) report("kind", out_ch.result_kind, w.result_kind);
        if (out_ch.out_char !== w.out_char) report("char", out_ch.out_char, w.out_char);
        if (out_ch.fg_mode !== w.fg_mode) report("fg_mode", out_ch.fg_mode, w.fg_mode);
        if (out_ch.fg_value !== w.fg_value) report("fg_value", out_ch.fg_value, w.fg_value);
        if (out_ch.bg_mode !== w.bg_mode) report("bg_mode", out_ch.bg_mode, w.bg_mode);
        if (out_ch.bg_value !== w.bg_value) report("bg_value", out_ch.bg_value, w.bg_value);
        if (out_ch.style_flags !== w.style_flags) report("flags", out_ch.style_flags, w.style_flags);
        if (out_ch.cursor_row !== w.cursor_row) report("row", out_ch.cursor_row, w.cursor_row);
        if (out_ch.cursor_col !== w.cursor_col) report("col", out_ch.cursor_col, w.cursor_col);
        if (out_ch.erase_mode !== w.erase_mode) report("erase", out_ch.erase_mode, w.erase_mode);
      end
    end
  end

  // Stall watchdog: no beat on either channel for too long ends the run.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("ansi_csi_escape_parser_unit: mismatch");
      $finish;
    end
  end

  // Result receiver, with a long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
      end
      out_ch.ready = ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit typed, input res_t want);
    bit has;
    res_t r;
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.in_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    parse_byte(b, has, r);
    if (typed) pending_results.push_back(want);
    else if (has) pending_results.push_back(r);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic put_number(input int v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) byte_stream.push_back(s[i]);
  endtask

  function automatic int pick_param();
    int k;
    k = $urandom_range(9);
    case (k)
      0: return $urandom_range(3);
      1: return SGR_INVERT;
      2: return SGR_CLR_BASE + $urandom_range(2);
      3: return SGR_FG_BASE + $urandom_range(9);
      4: return SGR_BG_BASE + $urandom_range(9);
      5: return SGR_FG_BRT + $urandom_range(7);
      6: return SGR_BG_BRT + $urandom_range(7);
      7: return $urandom_range(999999);
      default: return $urandom_range(255);
    endcase
  endfunction

  // Appends one piece of traffic: mostly well-formed CSI sequences.
  task automatic gen_piece();
    int k, cnt;
    logic [7:0] fin;
    k = $urandom_range(99);
    if (k < 15) begin
      byte_stream.push_back(8'($urandom_range(255)));
    end else if (k < 22) begin
      byte_stream.push_back(CH_ESC);
      byte_stream.push_back(8'($urandom_range(255)));
    end else begin
      byte_stream.push_back(CH_ESC);
      byte_stream.push_back(CH_LBRK);
      cnt = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 6);
      for (int i = 0; i < cnt; i++) begin
        if (i > 0) byte_stream.push_back(CH_SEMI);
        k = $urandom_range(9);
        if (k < 2) begin
          put_number($urandom_range(1) ? SGR_FG_EXT : SGR_BG_EXT);
          byte_stream.push_back(CH_SEMI);
          k = $urandom_range(9);
          if (k < 4) begin
            put_number(SEL_IDX);
            byte_stream.push_back(CH_SEMI);
            put_number($urandom_range(300));
          end else if (k < 8) begin
            put_number(SEL_RGB);
            for (int j = 0; j < 3; j++) begin
              byte_stream.push_back(CH_SEMI);
              put_number($urandom_range(300));
            end
          end else put_number($urandom_range(300));
          i += 2;
        end else if (k > 2) put_number(pick_param());
      end
      k = $urandom_range(11);
      case (k)
        0, 1, 2, 3: fin = CH_LOW_M;
        4: fin = CH_UP_H;
        5: fin = CH_LOW_F;
        6, 7: fin = CH_UP_K;
        8, 9: fin = CH_UP_J;
        default: fin = 8'($urandom_range(8'h40, 8'h7E));
      endcase
      byte_stream.push_back(fin);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_WIDTH:  m_width = val;
      REG_HEIGHT: m_height = val;
      REG_DFG:    m_dfg = val[3:0];
      default:    m_dbg = val[3:0];
    endcase
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic add_row(input logic [7:0] b, input bit typed, input res_t want);
    row_t r;
    r.b = b; r.typed = typed; r.want = want;
    directed_rows.push_back(r);
  endtask

  initial begin
    res_t e;
    res_t none;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'd0;
    m_width = WIDTH_RESET; m_height = HEIGHT_RESET;
    m_dfg = DFG_RESET; m_dbg = DBG_RESET;
    m_phase = PH_TEXT;
    clear_stack();
    m_fg_mode = MODE_PAL; m_fg_val = 24'(DFG_RESET);
    m_bg_mode = MODE_PAL; m_bg_val = 24'(DBG_RESET);
    m_flags = '0;
    none = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    e = '0; e.result_kind = KIND_CHAR; e.out_char = 8'h41;
    add_row(8'h41, 1'b1, e);
    e.out_char = 8'h00;
    add_row(8'h00, 1'b1, e);
    // A lone ESC lets the next byte through, another ESC included.
    add_row(CH_ESC, 1'b0, none);
    e.out_char = 8'h78;
    add_row(8'h78, 1'b1, e);
    add_row(CH_ESC, 1'b0, none);
    e.out_char = CH_ESC;
    add_row(CH_ESC, 1'b1, e);
    add_row(CH_ESC, 1'b0, none);
    add_row(CH_LBRK, 1'b0, none);
    e = '0; e.result_kind = KIND_STYLE;
    e.fg_value = 24'(DFG_RESET); e.bg_value = 24'(DBG_RESET);
    add_row(CH_LOW_M, 1'b1, e);
    // Saturated row parameter clamps to the last row; missing column gives 0.
    add_row(CH_ESC, 1'b0, none);
    add_row(CH_LBRK, 1'b0, none);
    for (int i = 0; i < 6; i++) add_row(CH_NINE, 1'b0, none);
    e = '0; e.result_kind = KIND_CURSOR; e.cursor_row = HEIGHT_RESET - 8'd1;
    add_row(CH_UP_H, 1'b1, e);
    add_row(CH_ESC, 1'b0, none);
    add_row(CH_LBRK, 1'b0, none);
    add_row(CH_ZERO + 8'd5, 1'b0, none);
    e = '0; e.result_kind = KIND_ELINE;
    add_row(CH_UP_K, 1'b1, e);
    add_row(CH_ESC, 1'b0, none);
    add_row(CH_LBRK, 1'b0, none);
    add_row(CH_ZERO + 8'd2, 1'b0, none);
    e = '0; e.result_kind = KIND_ESCR; e.erase_mode = 2'd2;
    add_row(CH_UP_J, 1'b1, e);

    @(negedge clk);
    foreach (directed_rows[i]) send_byte(directed_rows[i].b, directed_rows[i].typed,
                                         directed_rows[i].want);

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      if (ph == 0) begin
        write_reg(REG_WIDTH, 8'd1); write_reg(REG_HEIGHT, 8'd255);
        write_reg(REG_DFG, 8'd0); write_reg(REG_DBG, 8'd15);
        tx_idle = 31; rx_idle = 86;
      end else if (ph == 1) begin
        write_reg(REG_WIDTH, 8'd255); write_reg(REG_HEIGHT, 8'd1);
        write_reg(REG_DFG, 8'd15); write_reg(REG_DBG, 8'd0);
        tx_idle = 86; rx_idle = 31;
      end else begin
        write_reg(REG_WIDTH, 8'($urandom_range(1, 255)));
        write_reg(REG_HEIGHT, 8'($urandom_range(1, 255)));
        write_reg(REG_DFG, 8'($urandom_range(15)));
        write_reg(REG_DBG, 8'($urandom_range(15)));
        tx_idle = 0; rx_idle = 0;
        hold_req = 1'b1;
      end
      byte_stream.delete();
      while (byte_stream.size() < 570) gen_piece();
      while (byte_stream.size() != 0) send_byte(byte_stream.pop_front(), 1'b0, none);
    end

    while (pending_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fails == 0) $display("ansi_csi_escape_parser_unit: match");
    else $display("ansi_csi_escape_parser_unit: mismatch");
    $finish;
  end
endmodule
